// ----- rtl/ssp_pkg.sv -----
// Shared constants, queue entry type and CRC fold function for the SSP frame encoder.
package ssp_pkg;

  localparam logic [7:0] FEND_BYTE  = 8'hC0;
  localparam logic [7:0] FESC_BYTE  = 8'hDB;
  localparam logic [7:0] TFEND_BYTE = 8'hDC;
  localparam logic [7:0] TFESC_BYTE = 8'hDD;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [7:0] POLY_RESET = 8'h8C;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       esc;
    logic [7:0] esc_byte;
    logic [7:0] dest;
    logic [7:0] src;
    logic [7:0] ftype;
    logic [7:0] crc;
  } cmd_t;

  function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] ch,
                                          input logic [7:0] poly);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[0] ^ ch[i]) begin
        c = (c >> 1) ^ poly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/ssp_front.sv -----
// Front end: accepts payload bytes, runs the CRC, classifies stuffing, builds queue entries.
module ssp_front import ssp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] payload_byte,
  input  logic       first_of_frame,
  input  logic       last_of_frame,
  input  logic [7:0] dest_address,
  input  logic [7:0] source_address,
  input  logic [7:0] frame_type,
  output logic       push_valid,
  input  logic       push_ready,
  output cmd_t       push_cmd
);

  logic [7:0] crc_polynomial;
  logic [7:0] crc_accum;
  logic [7:0] crc_base;
  logic [7:0] crc_new;
  logic       in_fire;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign in_fire    = in_valid && push_ready;

  assign crc_base = first_of_frame ? CRC_INIT : crc_accum;
  assign crc_new  = crc_fold(crc_base, payload_byte, crc_polynomial);

  always_comb begin
    push_cmd.data     = payload_byte;
    push_cmd.first    = first_of_frame;
    push_cmd.last     = last_of_frame;
    push_cmd.esc      = (payload_byte == FEND_BYTE) || (payload_byte == FESC_BYTE);
    push_cmd.esc_byte = (payload_byte == FEND_BYTE) ? TFEND_BYTE : TFESC_BYTE;
    push_cmd.dest     = dest_address;
    push_cmd.src      = source_address;
    push_cmd.ftype    = frame_type;
    push_cmd.crc      = crc_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_polynomial <= POLY_RESET;
      crc_accum      <= CRC_INIT;
    end else begin
      if (cfg_write_en) begin
        crc_polynomial <= cfg_write_data;
      end
      if (in_fire) begin
        crc_accum <= last_of_frame ? CRC_INIT : crc_new;
      end
    end
  end

  a_crc_restart: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_of_frame |=> crc_accum == CRC_INIT)
    else $error("CRC not restarted after frame end");

endmodule

// ----- rtl/ssp_queue.sv -----
// Two-entry queue between the front end and the byte emitter.
module ssp_queue import ssp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              push_fire;
  logic              pop_fire;

  localparam logic [QPTR_W:0] DEPTH_CNT = QPTR_W'(QUEUE_DEPTH) == '0 ?
    {1'b1, {QPTR_W{1'b0}}} : (QPTR_W + 1)'(QUEUE_DEPTH);

  assign push_ready = count != DEPTH_CNT;
  assign pop_valid  = count != '0;
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;
  assign pop_cmd    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_CNT)
    else $error("queue count past depth");

endmodule

// ----- rtl/ssp_back.sv -----
// Back end: stuffs each queue entry's data; header on first, trailer on last.
module ssp_back import ssp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_pop,
  input  cmd_t       cmd,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       frame_end
);

  typedef enum logic [8:0] {
    S_BEGIN      = 9'b000000001,
    S_FEND_OPEN  = 9'b000000010,
    S_DEST       = 9'b000000100,
    S_SRC        = 9'b000001000,
    S_TYPE       = 9'b000010000,
    S_DATA       = 9'b000100000,
    S_ESC2       = 9'b001000000,
    S_CRC        = 9'b010000000,
    S_FEND_CLOSE = 9'b100000000
  } step_t;

  step_t      step;
  step_t      step_next;
  step_t      cur;
  logic [7:0] byte_sel;
  logic       done;
  logic       load;
  logic       fire;

  assign load    = !out_valid || out_ready;
  assign fire    = load && cmd_valid;
  assign cmd_pop = fire && done;

  always_comb begin
    if (step == S_BEGIN) begin
      cur = cmd.first ? S_FEND_OPEN : S_DATA;
    end else begin
      cur = step;
    end
  end

  always_comb begin
    byte_sel  = cmd.data;
    done      = 1'b0;
    step_next = S_BEGIN;
    case (cur)
      S_FEND_OPEN: begin
        byte_sel  = FEND_BYTE;
        step_next = S_DEST;
      end
      S_DEST: begin
        byte_sel  = cmd.dest;
        step_next = S_SRC;
      end
      S_SRC: begin
        byte_sel  = cmd.src;
        step_next = S_TYPE;
      end
      S_TYPE: begin
        byte_sel  = cmd.ftype;
        step_next = S_DATA;
      end
      S_DATA: begin
        byte_sel = cmd.esc ? FESC_BYTE : cmd.data;
        if (cmd.esc) begin
          step_next = S_ESC2;
        end else if (cmd.last) begin
          step_next = S_CRC;
        end else begin
          done = 1'b1;
        end
      end
      S_ESC2: begin
        byte_sel = cmd.esc_byte;
        if (cmd.last) begin
          step_next = S_CRC;
        end else begin
          done = 1'b1;
        end
      end
      S_CRC: begin
        byte_sel  = cmd.crc;
        step_next = S_FEND_CLOSE;
      end
      S_FEND_CLOSE: begin
        byte_sel = FEND_BYTE;
        done     = 1'b1;
      end
      default: begin
        byte_sel = cmd.data;
        done     = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= S_BEGIN;
    end else begin
      if (load) begin
        out_valid <= cmd_valid;
      end
      if (fire) begin
        step <= done ? S_BEGIN : step_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte  <= byte_sel;
      run_end   <= done;
      frame_end <= cur == S_FEND_CLOSE;
    end
  end

  a_frame_end_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_end && out_byte == FEND_BYTE)
    else $error("frame end not on closing FEND");

  a_begin_after_pop: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |=> step == S_BEGIN)
    else $error("step not back at begin after entry done");

endmodule

// ----- rtl/ssp_frame_encoder.sv -----
// Top level of the SSP frame encoder: KISS byte stuffing with a reflected CRC-8 trailer.
//
//  channel  handshake             payload
//  in       in_valid / in_ready   payload_byte, first/last marks, dest, source, type
//  out      out_valid / out_ready out_byte, run_end, frame_end
//  cfg      cfg_write_en          cfg_write_data -> crc_polynomial
//
// One line byte per cycle from the output register while out_ready is high and the queue
// holds an entry; a payload byte is 1 or 2 line bytes, plus 4 header and 2 trailer bytes,
// set by the back end's steps. The front end takes a byte per cycle while the two-entry
// queue has room; CRC is computed on acceptance. Synchronous reset empties queue and
// sequencer, sets CRC to 0xFF and polynomial to 0x8C.
// out_ready low holds the output register; the queue absorbs up to two more bytes.
module ssp_frame_encoder import ssp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] payload_byte,
  input  logic       first_of_frame,
  input  logic       last_of_frame,
  input  logic [7:0] dest_address,
  input  logic [7:0] source_address,
  input  logic [7:0] frame_type,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       frame_end
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  ssp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .payload_byte   (payload_byte),
    .first_of_frame (first_of_frame),
    .last_of_frame  (last_of_frame),
    .dest_address   (dest_address),
    .source_address (source_address),
    .frame_type     (frame_type),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd)
  );

  ssp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  ssp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd_pop   (pop_ready),
    .cmd       (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .run_end   (run_end),
    .frame_end (frame_end)
  );

endmodule
